>>> rtl/bbrs_pkg.sv
// Package for the buffer-based rate selector: payload word types,
// register map, operation and reason codes. No dependencies.
package bbrs_pkg;

  localparam int MAX_LEVELS = 16;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_BUFFER_MIN  = 3'd0;
  localparam logic [2:0] REG_BUFFER_LOW  = 3'd1;
  localparam logic [2:0] REG_BUFFER_HIGH = 3'd2;
  localparam logic [2:0] REG_ALPHA_STOP  = 3'd3;
  localparam logic [2:0] REG_ALPHA_LOW   = 3'd4;
  localparam logic [2:0] REG_ALPHA_MID   = 3'd5;
  localparam logic [2:0] REG_ALPHA_HIGH  = 3'd6;
  localparam logic [2:0] REG_ALPHA_STDY  = 3'd7;

  localparam logic [23:0] RST_BUFFER_MIN  = 24'd10000;
  localparam logic [23:0] RST_BUFFER_LOW  = 24'd20000;
  localparam logic [23:0] RST_BUFFER_HIGH = 24'd50000;
  localparam logic [9:0]  RST_ALPHA_STOP  = 10'd192;
  localparam logic [9:0]  RST_ALPHA_LOW   = 10'd84;
  localparam logic [9:0]  RST_ALPHA_MID   = 10'd128;
  localparam logic [9:0]  RST_ALPHA_HIGH  = 10'd192;
  localparam logic [9:0]  RST_ALPHA_STDY  = 10'd230;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECIDE = 1'b1;

  localparam logic [3:0] RSN_FEW_REQUESTS = 4'd0;
  localparam logic [3:0] RSN_INIT_MIN_UP  = 4'd1;
  localparam logic [3:0] RSN_INIT_MIN_KEEP = 4'd2;
  localparam logic [3:0] RSN_INIT_MID_UP  = 4'd3;
  localparam logic [3:0] RSN_INIT_MID_KEEP = 4'd4;
  localparam logic [3:0] RSN_INIT_HI_UP   = 4'd5;
  localparam logic [3:0] RSN_INIT_HI_KEEP = 4'd6;
  localparam logic [3:0] RSN_ST_LOWEST    = 4'd7;
  localparam logic [3:0] RSN_ST_AT_BOTTOM = 4'd8;
  localparam logic [3:0] RSN_ST_KEEP      = 4'd9;
  localparam logic [3:0] RSN_ST_DOWN      = 4'd10;
  localparam logic [3:0] RSN_ST_MID_DELAY = 4'd11;
  localparam logic [3:0] RSN_ST_MID_NONE  = 4'd12;
  localparam logic [3:0] RSN_ST_HI_DELAY  = 4'd13;
  localparam logic [3:0] RSN_ST_UP        = 4'd14;
  localparam logic [3:0] RSN_LOADED       = 4'd15;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  level_index;
    logic [23:0] level_bandwidth_kbps;
    logic [15:0] level_segment_ms;
    logic        min_level_rising;
    logic [23:0] buffer_level_ms;
    logic [23:0] throughput_kbps;
    logic [23:0] last_throughput_kbps;
    logic [15:0] done_requests;
    logic [15:0] needed_requests;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  chosen_index;
    logic        delay_valid;
    logic [23:0] delay_target_ms;
    logic [3:0]  reason_code;
  } out_item_t;

endpackage

>>> rtl/buffer_based_rate_selector_core.sv
// Buffer-based rate selector core: level table, phase state and decision
// pipeline behind valid/ready channels and an APB register port.
// Depends on bbrs_pkg.
//
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order, from the output register. Stage one
// clamps the last level, forms the three alpha-times-throughput products
// and reads the 16-entry level table through two registered read ports;
// stage two does the compares and selects the result into the output
// register. Loads update the table and highest level as they leave stage
// one, so a decision may follow a load in the very next cycle.
module buffer_based_rate_selector_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bbrs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bbrs_pkg::out_item_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bbrs_pkg::CFG_AW-1:0]      paddr,
  input  logic [bbrs_pkg::CFG_DW-1:0]      pwdata,
  output logic [bbrs_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready
);

  logic [23:0] buf_min_r, buf_low_r, buf_high_r;
  logic [9:0]  a_stop_r, a_low_r, a_mid_r, a_high_r, a_stdy_r;
  logic        cfg_wr;

  logic [23:0] bw_mem  [bbrs_pkg::MAX_LEVELS];
  logic [15:0] seg_mem [bbrs_pkg::MAX_LEVELS];
  logic [3:0]  highest_r;
  logic        phase_r;

  logic                 s1_v_r;
  bbrs_pkg::in_item_t   s1_r;
  logic                 s2_v_r;
  logic                 out_v_r;
  bbrs_pkg::out_item_t  out_r;

  logic in_acc, out_free, s2_free, s1_free, s1_adv, s2_adv;

  logic [3:0]  s1_last, s1_nxt;
  logic        s1_few, s1_below_min, s1_below_low, s1_load_ok;
  logic [9:0]  s1_a_up;
  logic [24:0] s1_mid_sum;

  logic        s2_op_r, s2_few_r, s2_last_top_r, s2_rising_r;
  logic [3:0]  s2_idx_r, s2_last_r, s2_nxt_r;
  logic [23:0] s2_beta_r, s2_rho_last_r, s2_mid_r;
  logic        s2_below_min_r, s2_below_low_r, s2_below_high_r;
  logic [33:0] s2_p_stop_r, s2_p_up_r, s2_p_stdy_r;
  logic [23:0] bw_last_r, bw_nxt_r;
  logic [15:0] seg_last_r, seg_nxt_r;

  logic        s2_phase_end, s2_init, s2_up, s2_hold;
  logic [33:0] sc_last, sc_nxt;
  logic [15:0] s2_seg_pick;
  logic [23:0] s2_init_dly, s2_beta_seg, s2_st_dly;
  bbrs_pkg::out_item_t s2_res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_min_r  <= bbrs_pkg::RST_BUFFER_MIN;
      buf_low_r  <= bbrs_pkg::RST_BUFFER_LOW;
      buf_high_r <= bbrs_pkg::RST_BUFFER_HIGH;
      a_stop_r   <= bbrs_pkg::RST_ALPHA_STOP;
      a_low_r    <= bbrs_pkg::RST_ALPHA_LOW;
      a_mid_r    <= bbrs_pkg::RST_ALPHA_MID;
      a_high_r   <= bbrs_pkg::RST_ALPHA_HIGH;
      a_stdy_r   <= bbrs_pkg::RST_ALPHA_STDY;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        bbrs_pkg::REG_BUFFER_MIN:  buf_min_r  <= pwdata[23:0];
        bbrs_pkg::REG_BUFFER_LOW:  buf_low_r  <= pwdata[23:0];
        bbrs_pkg::REG_BUFFER_HIGH: buf_high_r <= pwdata[23:0];
        bbrs_pkg::REG_ALPHA_STOP:  a_stop_r   <= pwdata[9:0];
        bbrs_pkg::REG_ALPHA_LOW:   a_low_r    <= pwdata[9:0];
        bbrs_pkg::REG_ALPHA_MID:   a_mid_r    <= pwdata[9:0];
        bbrs_pkg::REG_ALPHA_HIGH:  a_high_r   <= pwdata[9:0];
        bbrs_pkg::REG_ALPHA_STDY:  a_stdy_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bbrs_pkg::REG_BUFFER_MIN:  prdata = {8'd0, buf_min_r};
      bbrs_pkg::REG_BUFFER_LOW:  prdata = {8'd0, buf_low_r};
      bbrs_pkg::REG_BUFFER_HIGH: prdata = {8'd0, buf_high_r};
      bbrs_pkg::REG_ALPHA_STOP:  prdata = {22'd0, a_stop_r};
      bbrs_pkg::REG_ALPHA_LOW:   prdata = {22'd0, a_low_r};
      bbrs_pkg::REG_ALPHA_MID:   prdata = {22'd0, a_mid_r};
      bbrs_pkg::REG_ALPHA_HIGH:  prdata = {22'd0, a_high_r};
      bbrs_pkg::REG_ALPHA_STDY:  prdata = {22'd0, a_stdy_r};
      default:                   prdata = '0;
    endcase
  end

  // pipeline flow control
  assign out_free = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && s1_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign s2_adv   = s2_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
  end

  // stage one: clamp, region flags, products
  assign s1_last      = (s1_r.level_index > highest_r) ? highest_r : s1_r.level_index;
  assign s1_nxt       = s1_last + 4'd1;
  assign s1_few       = (s1_r.done_requests == 16'd0) ||
                        (s1_r.done_requests < s1_r.needed_requests);
  assign s1_below_min = s1_r.buffer_level_ms < buf_min_r;
  assign s1_below_low = s1_r.buffer_level_ms < buf_low_r;
  assign s1_a_up      = s1_below_min ? a_low_r : (s1_below_low ? a_mid_r : a_high_r);
  assign s1_mid_sum   = {1'b0, buf_low_r} + {1'b0, buf_high_r};
  assign s1_load_ok   = (s1_r.opcode == bbrs_pkg::OP_LOAD) &&
                        (int'(s1_r.level_index) < bbrs_pkg::MAX_LEVELS);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_load_ok) begin
        bw_mem[s1_r.level_index]  <= s1_r.level_bandwidth_kbps;
        seg_mem[s1_r.level_index] <= s1_r.level_segment_ms;
      end
      bw_last_r  <= bw_mem[s1_last];
      bw_nxt_r   <= bw_mem[s1_nxt];
      seg_last_r <= seg_mem[s1_last];
      seg_nxt_r  <= seg_mem[s1_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_op_r         <= s1_r.opcode;
      s2_idx_r        <= s1_r.level_index;
      s2_few_r        <= s1_few;
      s2_last_r       <= s1_last;
      s2_nxt_r        <= s1_nxt;
      s2_last_top_r   <= s1_last == highest_r;
      s2_rising_r     <= s1_r.min_level_rising;
      s2_beta_r       <= s1_r.buffer_level_ms;
      s2_rho_last_r   <= s1_r.last_throughput_kbps;
      s2_mid_r        <= s1_mid_sum[24:1];
      s2_below_min_r  <= s1_below_min;
      s2_below_low_r  <= s1_below_low;
      s2_below_high_r <= s1_r.buffer_level_ms < buf_high_r;
      s2_p_stop_r     <= {24'd0, a_stop_r} * {10'd0, s1_r.throughput_kbps};
      s2_p_up_r       <= {24'd0, s1_a_up} * {10'd0, s1_r.throughput_kbps};
      s2_p_stdy_r     <= {24'd0, a_stdy_r} * {10'd0, s1_r.throughput_kbps};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r <= '0;
      phase_r   <= 1'b1;
    end else begin
      if (s1_adv && s1_load_ok) begin
        highest_r <= s1_r.level_index;
      end
      if (s2_adv && (s2_op_r == bbrs_pkg::OP_DECIDE) && !s2_few_r && s2_phase_end) begin
        phase_r <= 1'b0;
      end
    end
  end

  // stage two: compares and result select
  assign sc_last      = {2'd0, bw_last_r, 8'd0};
  assign sc_nxt       = {2'd0, bw_nxt_r, 8'd0};
  assign s2_phase_end = s2_last_top_r || !s2_rising_r || (sc_last > s2_p_stop_r);
  assign s2_init      = phase_r && !s2_phase_end;
  assign s2_up        = sc_nxt <= s2_p_up_r;
  assign s2_hold      = s2_last_top_r || (sc_nxt >= s2_p_stdy_r);
  assign s2_seg_pick  = s2_up ? seg_nxt_r : seg_last_r;
  assign s2_init_dly  = (buf_high_r > {8'd0, s2_seg_pick}) ?
                        buf_high_r - {8'd0, s2_seg_pick} : 24'd0;
  assign s2_beta_seg  = (s2_beta_r > {8'd0, seg_last_r}) ?
                        s2_beta_r - {8'd0, seg_last_r} : 24'd0;
  assign s2_st_dly    = (s2_beta_seg < s2_mid_r) ? s2_mid_r : s2_beta_seg;

  always_comb begin
    s2_res = '0;
    s2_res.chosen_index = s2_last_r;
    if (s2_op_r == bbrs_pkg::OP_LOAD) begin
      s2_res.chosen_index = s2_idx_r;
      s2_res.reason_code  = bbrs_pkg::RSN_LOADED;
    end else if (s2_few_r) begin
      s2_res.chosen_index = 4'd0;
      s2_res.reason_code  = bbrs_pkg::RSN_FEW_REQUESTS;
    end else if (s2_init) begin
      if (s2_up) begin
        s2_res.chosen_index = s2_nxt_r;
      end
      if (s2_below_min_r) begin
        s2_res.reason_code = s2_up ? bbrs_pkg::RSN_INIT_MIN_UP : bbrs_pkg::RSN_INIT_MIN_KEEP;
      end else if (s2_below_low_r) begin
        s2_res.reason_code = s2_up ? bbrs_pkg::RSN_INIT_MID_UP : bbrs_pkg::RSN_INIT_MID_KEEP;
      end else begin
        s2_res.reason_code     = s2_up ? bbrs_pkg::RSN_INIT_HI_UP : bbrs_pkg::RSN_INIT_HI_KEEP;
        s2_res.delay_valid     = 1'b1;
        s2_res.delay_target_ms = s2_init_dly;
      end
    end else if (s2_below_min_r) begin
      s2_res.chosen_index = 4'd0;
      s2_res.reason_code  = bbrs_pkg::RSN_ST_LOWEST;
    end else if (s2_below_low_r) begin
      if (s2_last_r == 4'd0) begin
        s2_res.reason_code = bbrs_pkg::RSN_ST_AT_BOTTOM;
      end else if (s2_rho_last_r > bw_last_r) begin
        s2_res.reason_code = bbrs_pkg::RSN_ST_KEEP;
      end else begin
        s2_res.chosen_index = s2_last_r - 4'd1;
        s2_res.reason_code  = bbrs_pkg::RSN_ST_DOWN;
      end
    end else if (s2_hold) begin
      s2_res.delay_valid     = 1'b1;
      s2_res.delay_target_ms = s2_st_dly;
      s2_res.reason_code     = s2_below_high_r ? bbrs_pkg::RSN_ST_MID_DELAY :
                                                 bbrs_pkg::RSN_ST_HI_DELAY;
    end else if (s2_below_high_r) begin
      s2_res.reason_code = bbrs_pkg::RSN_ST_MID_NONE;
    end else begin
      s2_res.chosen_index = s2_nxt_r;
      s2_res.reason_code  = bbrs_pkg::RSN_ST_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_r <= s2_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
